/* rtl/core/sddf_pkg.sv */
// ----------------------------------------------------------------------------
// sddf_pkg
// Shared types and constants for the signed decimal digit formatter.
// ----------------------------------------------------------------------------
package sddf_pkg;

    // Field widths
    localparam int VALUE_W    = 32;
    localparam int CFG_W      = 4;
    localparam int POS_W      = 3;
    localparam int SYM_W      = 4;
    localparam int CNT_W      = 5;   // holds a position count up to 31
    localparam int STEP_W     = 5;   // one shift step per magnitude bit
    localparam int LEN_W      = 4;   // significant digit count, 1..10
    localparam int BCD_DIGITS = 10;  // enough for 2147483648

    // Symbol codes
    localparam logic [SYM_W-1:0] SYM_MINUS = 4'd10;
    localparam logic [SYM_W-1:0] SYM_BLANK = 4'd11;

    typedef logic [BCD_DIGITS-1:0][3:0] t_bcd;

    // Commands from the sequencer to the conversion unit
    typedef struct packed {
        logic load;
        logic step;
    } t_dab_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LEN,
        ST_EMIT
    } t_state;

endpackage

/* rtl/core/signed_decimal_digit_formatter_top.sv */
// ----------------------------------------------------------------------------
// signed_decimal_digit_formatter_top
// Formats a signed 32-bit number as right-justified decimal display symbols.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  input     in         i_valid / o_stall  i_value[31:0]
//  output    out        o_valid / i_stall  o_position[2:0], o_symbol[3:0], o_last
//  config    in         APB write/read     digit_count at every address
//
//  One transaction runs an accept state, 32 shift steps of the BCD unit,
//  a sizing state, then emits one symbol per cycle per active position
//  while the output is not stalled. The shift-and-add-3 unit sets the
//  conversion time; i_stall only delays the emit phase. Reset is
//  synchronous, active low, and clears digit_count.
// ----------------------------------------------------------------------------
module signed_decimal_digit_formatter_top #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // APB configuration port
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [1:0]                     i_paddr,
    input  logic [31:0]                    i_pwdata,
    output logic [31:0]                    o_prdata,
    output logic                           o_pready,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [sddf_pkg::VALUE_W-1:0]   i_value,
    // output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [sddf_pkg::POS_W-1:0]     o_position,
    output logic [sddf_pkg::SYM_W-1:0]     o_symbol,
    output logic                           o_last
);

    logic [sddf_pkg::CFG_W-1:0] r_digit_count;
    logic                       w_wr;
    sddf_pkg::t_dab_ctrl        w_ctrl;
    sddf_pkg::t_bcd             w_bcd;
    logic                       w_neg;

    // Single register; all addresses decode to it
    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite && o_pready && (i_paddr[1:0] == i_paddr);
    assign o_prdata = {{(32 - sddf_pkg::CFG_W){1'b0}}, r_digit_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= '0;
        end else if (w_wr) begin
            r_digit_count <= i_pwdata[sddf_pkg::CFG_W-1:0];
        end
    end

    // Conversion unit
    sddf_dabble u_dabble (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_value (i_value),
        .o_bcd   (w_bcd),
        .o_neg   (w_neg)
    );

    // Sequencer and output register
    sddf_seq #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_digit_count (r_digit_count),
        .o_ctrl        (w_ctrl),
        .i_bcd         (w_bcd),
        .i_neg         (w_neg),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_position    (o_position),
        .o_symbol      (o_symbol),
        .o_last        (o_last)
    );

endmodule

/* rtl/core/sddf_dabble.sv */
// ----------------------------------------------------------------------------
// sddf_dabble
// Shift-and-add-3 binary to BCD unit, one magnitude bit per step.
// ----------------------------------------------------------------------------
module sddf_dabble (
    input  logic                               i_clk,
    input  sddf_pkg::t_dab_ctrl                i_ctrl,
    input  logic [sddf_pkg::VALUE_W-1:0]       i_value,
    output sddf_pkg::t_bcd                     o_bcd,
    output logic                               o_neg
);

    localparam int BCD_BITS = 4 * sddf_pkg::BCD_DIGITS;

    logic [sddf_pkg::VALUE_W-1:0] r_bin;
    sddf_pkg::t_bcd               r_bcd;
    logic                         r_neg;
    sddf_pkg::t_bcd               w_adj;
    logic [BCD_BITS-1:0]          w_adj_bits;

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int j = 0; j < sddf_pkg::BCD_DIGITS; j++) begin
            w_adj[j] = (r_bcd[j] >= 4'd5) ? r_bcd[j] + 4'd3 : r_bcd[j];
        end
    end

    assign w_adj_bits = w_adj;

    // Load magnitude, then shift one bit into the BCD field per step
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_neg <= i_value[sddf_pkg::VALUE_W-1];
            r_bin <= i_value[sddf_pkg::VALUE_W-1] ? (~i_value + 1'b1) : i_value;
            r_bcd <= '0;
        end else if (i_ctrl.step) begin
            r_bcd <= {w_adj_bits[BCD_BITS-2:0], r_bin[sddf_pkg::VALUE_W-1]};
            r_bin <= {r_bin[sddf_pkg::VALUE_W-2:0], 1'b0};
        end
    end

    assign o_bcd = r_bcd;
    assign o_neg = r_neg;

endmodule

/* rtl/core/sddf_seq.sv */
// ----------------------------------------------------------------------------
// sddf_seq
// Sequencer: runs the conversion steps, sizes the number, emits symbols.
// ----------------------------------------------------------------------------
module sddf_seq #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel handshake
    input  logic                           i_valid,
    output logic                           o_stall,
    // configuration
    input  logic [sddf_pkg::CFG_W-1:0]     i_digit_count,
    // conversion unit
    output sddf_pkg::t_dab_ctrl            o_ctrl,
    input  sddf_pkg::t_bcd                 i_bcd,
    input  logic                           i_neg,
    // output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [sddf_pkg::POS_W-1:0]     o_position,
    output logic [sddf_pkg::SYM_W-1:0]     o_symbol,
    output logic                           o_last
);

    localparam int CNT_W = sddf_pkg::CNT_W;

    sddf_pkg::t_state                 r_state, n_state;
    logic [sddf_pkg::STEP_W-1:0]      r_step, n_step;
    logic [CNT_W-1:0]                 r_n, n_n;
    logic [CNT_W-1:0]                 r_pos, n_pos;
    logic [sddf_pkg::LEN_W-1:0]       r_len, n_len;
    logic                             r_valid, n_valid;
    logic [sddf_pkg::POS_W-1:0]       r_position, n_position;
    logic [sddf_pkg::SYM_W-1:0]       r_symbol, n_symbol;
    logic                             r_last, n_last;

    logic                             w_accept;
    logic                             w_out_free;
    logic [CNT_W-1:0]                 w_count;
    logic [sddf_pkg::LEN_W-1:0]       w_len;
    logic [CNT_W-1:0]                 w_k;
    logic [CNT_W-1:0]                 w_len_ext;
    logic [3:0]                       w_digit;
    logic [sddf_pkg::SYM_W-1:0]       w_sym;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_valid || !i_stall;

    // Active positions: zero or out of range means the maximum
    always_comb begin
        if (i_digit_count == '0 ||
            CNT_W'(i_digit_count) > CNT_W'(MAX_DIGITS)) begin
            w_count = CNT_W'(MAX_DIGITS);
        end else begin
            w_count = CNT_W'(i_digit_count);
        end
    end

    // Significant digits of the magnitude, at least one
    always_comb begin
        w_len = sddf_pkg::LEN_W'(1);
        for (int j = 1; j < sddf_pkg::BCD_DIGITS; j++) begin
            if (i_bcd[j] != 4'd0) begin
                w_len = sddf_pkg::LEN_W'(j + 1);
            end
        end
    end

    // Digit index from the right for the current position
    assign w_k       = r_n - CNT_W'(1) - r_pos;
    assign w_len_ext = CNT_W'(r_len);

    always_comb begin
        w_digit = 4'd0;
        for (int j = 0; j < sddf_pkg::BCD_DIGITS; j++) begin
            if (w_k == CNT_W'(j)) begin
                w_digit = i_bcd[j];
            end
        end
    end

    // Symbol for the current position
    always_comb begin
        if (i_neg && (w_len_ext > r_n) && (r_pos == '0)) begin
            w_sym = sddf_pkg::SYM_MINUS;   // overflowing negative
        end else if (w_k < w_len_ext) begin
            w_sym = w_digit;
        end else if (i_neg && (w_k == w_len_ext)) begin
            w_sym = sddf_pkg::SYM_MINUS;
        end else begin
            w_sym = sddf_pkg::SYM_BLANK;
        end
    end

    // Next state and outputs
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_n        = r_n;
        n_pos      = r_pos;
        n_len      = r_len;
        n_valid    = w_out_free ? 1'b0 : r_valid;
        n_position = r_position;
        n_symbol   = r_symbol;
        n_last     = r_last;
        o_ctrl     = '0;
        o_stall    = 1'b1;

        case (r_state)
            sddf_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (w_accept) begin
                    o_ctrl.load = 1'b1;
                    n_n         = w_count;
                    n_step      = '0;
                    n_state     = sddf_pkg::ST_CONV;
                end
            end
            sddf_pkg::ST_CONV: begin
                o_ctrl.step = 1'b1;
                n_step      = r_step + 1'b1;
                if (r_step == '1) begin
                    n_state = sddf_pkg::ST_LEN;
                end
            end
            sddf_pkg::ST_LEN: begin
                n_len   = w_len;
                n_pos   = '0;
                n_state = sddf_pkg::ST_EMIT;
            end
            sddf_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_valid    = 1'b1;
                    n_position = r_pos[sddf_pkg::POS_W-1:0];
                    n_symbol   = w_sym;
                    n_last     = (r_pos == r_n - CNT_W'(1));
                    n_pos      = r_pos + 1'b1;
                    if (r_pos == r_n - CNT_W'(1)) begin
                        n_state = sddf_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sddf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sddf_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Counters and output payload
    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_n        <= n_n;
        r_pos      <= n_pos;
        r_len      <= n_len;
        r_position <= n_position;
        r_symbol   <= n_symbol;
        r_last     <= n_last;
    end

    assign o_valid    = r_valid;
    assign o_position = r_position;
    assign o_symbol   = r_symbol;
    assign o_last     = r_last;

endmodule
